@@ rtl/tasr_pkg.sv @@
package tasr_pkg;

  localparam int RING_DEPTH = 4096;  // must be a power of two
  localparam int COUNT_BITS = 48;
  localparam int ADDR_BITS  = $clog2(RING_DEPTH);

  localparam int SAMPLE_BITS = 32;
  localparam int TAG_BITS    = 32;
  localparam int SLOT_BITS   = TAG_BITS + SAMPLE_BITS;
  localparam int OUT_BITS    = 48;
  localparam int UNDER_BITS  = 32;
  localparam int GEN_BITS    = 32;

  localparam logic [SAMPLE_BITS-1:0] POS_ONE  = 32'h3F80_0000;
  localparam logic [SAMPLE_BITS-1:0] NEG_ONE  = 32'hBF80_0000;
  localparam logic [SAMPLE_BITS-1:0] MAG_MASK = 32'h7FFF_FFFF;

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam count_t CNT_DEPTH = COUNT_BITS'(RING_DEPTH);

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // Everything the output stage needs besides the slot data.
  typedef struct packed {
    logic                   read_hit;
    logic [TAG_BITS-1:0]    want_tag;
    logic                   last;
    logic [OUT_BITS-1:0]    written;
    logic [OUT_BITS-1:0]    consumed;
    logic [UNDER_BITS-1:0]  underrun;
    logic [GEN_BITS-1:0]    generation;
  } side_t;

  function automatic logic bits_finite(input logic [SAMPLE_BITS-1:0] b);
    return b[30:23] != 8'hFF;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sanitize(input logic [SAMPLE_BITS-1:0] b);
    logic [SAMPLE_BITS-1:0] r;
    if (!bits_finite(b)) begin
      r = '0;
    end else if ((b & MAG_MASK) > POS_ONE) begin
      r = b[31] ? NEG_ONE : POS_ONE;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

@@ rtl/tasr_req_if.sv @@
interface tasr_req_if import tasr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             operation;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic                   last_in_burst;

  modport source (output valid, output operation, output sample_in, output last_in_burst,
                  input ready);
  modport sink   (input valid, input operation, input sample_in, input last_in_burst,
                  output ready);
endinterface

@@ rtl/tasr_rsp_if.sv @@
interface tasr_rsp_if import tasr_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   sample_valid;
  logic                   burst_end;
  logic [OUT_BITS-1:0]    written_count;
  logic [OUT_BITS-1:0]    consumed_count;
  logic [UNDER_BITS-1:0]  underrun_count;
  logic [GEN_BITS-1:0]    generation_out;

  modport source (output valid, output sample_out, output sample_valid, output burst_end,
                  output written_count, output consumed_count, output underrun_count,
                  output generation_out, input ready);
  modport sink   (input valid, input sample_out, input sample_valid, input burst_end,
                  input written_count, input consumed_count, input underrun_count,
                  input generation_out, output ready);
endinterface

@@ rtl/tasr_out_stage.sv @@
module tasr_out_stage import tasr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  side_t                side,
  input  logic [SLOT_BITS-1:0] rdata,
  output logic                 room,
  tasr_rsp_if.source           rsp
);

  logic  s1_valid;
  side_t s1_side;
  logic  adv;
  logic  out_valid;
  logic  tag_ok;
  logic  hit;

  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   sample_valid;
  logic                   burst_end;
  logic [OUT_BITS-1:0]    written_count;
  logic [OUT_BITS-1:0]    consumed_count;
  logic [UNDER_BITS-1:0]  underrun_count;
  logic [GEN_BITS-1:0]    generation_out;

  assign adv  = s1_valid && (!out_valid || rsp.ready);
  assign room = !s1_valid || adv;

  // The slot data arrives in the cycle after the transaction is accepted; the tag is checked here.
  assign tag_ok = rdata[SLOT_BITS-1:SAMPLE_BITS] == s1_side.want_tag;
  assign hit    = s1_side.read_hit && tag_ok && bits_finite(rdata[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_side <= side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out     <= hit ? rdata[SAMPLE_BITS-1:0] : '0;
      sample_valid   <= hit;
      burst_end      <= s1_side.last;
      written_count  <= s1_side.written;
      consumed_count <= s1_side.consumed;
      underrun_count <= s1_side.underrun;
      generation_out <= s1_side.generation;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.sample_out     = sample_out;
  assign rsp.sample_valid   = sample_valid;
  assign rsp.burst_end      = burst_end;
  assign rsp.written_count  = written_count;
  assign rsp.consumed_count = consumed_count;
  assign rsp.underrun_count = underrun_count;
  assign rsp.generation_out = generation_out;

endmodule

@@ rtl/tagged_audio_sample_ring_unit.sv @@
// Ring of tagged audio samples that takes one transaction per clock cycle, back to back,
// while the result side is ready, and returns one result transaction for each through the
// slot-data stage and the output register. Each write, and each read that finds a sample, makes
// one access to the single slot memory: a write stores the sanitized sample with its tag at the
// accept edge, and a read fetches the slot at the accept edge so the data is in hand in the next
// cycle, where the tag is checked. Writes land before any later read is issued, so no forwarding
// is needed. The slot memory has no clearing pass after reset: a slot is read only once it has
// been written in the current generation, so its power-up content never reaches a result.
module tagged_audio_sample_ring_unit import tasr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tasr_req_if.sink   req,
  tasr_rsp_if.source rsp
);

  logic [SLOT_BITS-1:0] slots [RING_DEPTH];
  logic [SLOT_BITS-1:0] rdata;

  count_t                write_count;
  count_t                read_cursor;
  logic [GEN_BITS-1:0]   generation_count;
  logic [GEN_BITS-1:0]   reader_generation;
  logic [UNDER_BITS-1:0] underrun_total;

  count_t                write_count_next;
  count_t                read_cursor_next;
  logic [GEN_BITS-1:0]   generation_count_next;
  logic [GEN_BITS-1:0]   reader_generation_next;
  logic [UNDER_BITS-1:0] underrun_total_next;

  logic   room;
  logic   accept;
  op_t    op;
  count_t floor_pos;
  count_t cur_a;
  count_t cur_b;
  count_t cur_c;
  logic   read_hit;
  logic   wr_en;
  logic   rd_en;
  side_t  side;

  assign req.ready = room;
  assign accept    = req.valid && room;
  assign op        = op_t'(req.operation);

  // Oldest index still held in the ring.
  assign floor_pos = (write_count > CNT_DEPTH) ? (write_count - CNT_DEPTH) : '0;
  // A stale reader jumps to the oldest sample; then the cursor is kept inside the window.
  assign cur_a    = (reader_generation != generation_count) ? floor_pos : read_cursor;
  assign cur_b    = (cur_a > write_count) ? write_count : cur_a;
  assign cur_c    = (cur_b < floor_pos) ? floor_pos : cur_b;
  assign read_hit = write_count > cur_c;

  always_comb begin
    write_count_next       = write_count;
    read_cursor_next       = read_cursor;
    generation_count_next  = generation_count;
    reader_generation_next = reader_generation;
    underrun_total_next    = underrun_total;
    wr_en                  = 1'b0;
    rd_en                  = 1'b0;
    unique case (op)
      OP_BEGIN: begin
        generation_count_next = (generation_count + GEN_BITS'(2)) & ~GEN_BITS'(1);
        write_count_next      = '0;
        read_cursor_next      = '0;
      end
      OP_WRITE: begin
        wr_en            = 1'b1;
        write_count_next = write_count + 1'b1;
      end
      OP_READ: begin
        reader_generation_next = generation_count;
        if (read_hit) begin
          rd_en            = 1'b1;
          read_cursor_next = cur_c + 1'b1;
        end else begin
          read_cursor_next = cur_c;
          if (underrun_total != '1) begin
            underrun_total_next = underrun_total + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count       <= '0;
      read_cursor       <= '0;
      generation_count  <= '0;
      reader_generation <= '0;
      underrun_total    <= '0;
    end else if (accept) begin
      write_count       <= write_count_next;
      read_cursor       <= read_cursor_next;
      generation_count  <= generation_count_next;
      reader_generation <= reader_generation_next;
      underrun_total    <= underrun_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      slots[write_count[ADDR_BITS-1:0]] <=
        {TAG_BITS'(write_count + 1'b1), sanitize(req.sample_in)};
    end
    if (accept && rd_en) begin
      rdata <= slots[cur_c[ADDR_BITS-1:0]];
    end
  end

  always_comb begin
    side.read_hit   = rd_en;
    side.want_tag   = TAG_BITS'(cur_c + 1'b1);
    side.last       = req.last_in_burst;
    side.written    = OUT_BITS'(write_count_next);
    side.consumed   = OUT_BITS'(read_cursor_next);
    side.underrun   = underrun_total_next;
    side.generation = generation_count_next;
  end

  tasr_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .take  (accept),
    .side  (side),
    .rdata (rdata),
    .room  (room),
    .rsp   (rsp)
  );

  // A stalled result must keep its slot data: no new read may be issued behind it.
  // The read data holds no value until the first read, so the check is exact.
  assert property (@(posedge clk) disable iff (rst) !room |=> rdata === $past(rdata))
    else $error("slot read data changed under a stalled result");

  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> underrun_total >= $past(underrun_total))
    else $error("underrun total decreased");

  assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_BEGIN |=> write_count == '0 && read_cursor == '0 &&
      generation_count[0] == 1'b0)
    else $error("new generation did not clear the counts");

endmodule

@@ sim/tagged_audio_sample_ring_unit_test.sv @@
`timescale 1ns / 1ps

module tagged_audio_sample_ring_unit_test;
  import tasr_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   sample_valid;
    logic                   burst_end;
    logic [OUT_BITS-1:0]    written_count;
    logic [OUT_BITS-1:0]    consumed_count;
    logic [UNDER_BITS-1:0]  underrun_count;
    logic [GEN_BITS-1:0]    generation_out;
  } ring_result_t;

  class ring_scoreboard;
    logic [SLOT_BITS-1:0]  slot_mem [RING_DEPTH];
    count_t                wr_count;
    count_t                rd_cursor;
    logic [GEN_BITS-1:0]   gen;
    logic [GEN_BITS-1:0]   reader_gen;
    logic                  synced;
    logic [UNDER_BITS-1:0] underruns;
    ring_result_t          expected_results [$];
    int mismatches, unexpected, checked;
    int reads, hits, zero_fills, overruns, resyncs, sanitized, begins;

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      wr_count = '0;
      rd_cursor = '0;
      gen = '0;
      reader_gen = '0;
      synced = 1'b1;
      underruns = '0;
    endfunction

    // Work out the result that one accepted transaction should produce.
    function void note_accepted(logic [1:0] op, logic [SAMPLE_BITS-1:0] smp, logic lst);
      ring_result_t want;
      logic [SAMPLE_BITS-1:0] clean;
      logic [SLOT_BITS-1:0] slot;
      want = '0;
      case (op)
        OP_BEGIN: begin
          gen = (gen + 32'd2) & ~32'd1;
          wr_count = '0;
          rd_cursor = '0;
          synced = 1'b1;
          begins++;
        end
        OP_WRITE: begin
          if (smp[30:23] == 8'hFF) begin
            clean = '0;
          end else if (smp[30:0] > POS_ONE[30:0]) begin
            clean = smp[31] ? NEG_ONE : POS_ONE;
          end else begin
            clean = smp;
          end
          if (clean != smp) sanitized++;
          slot_mem[wr_count[ADDR_BITS-1:0]] = {TAG_BITS'(wr_count + 1), clean};
          wr_count = wr_count + 1;
        end
        OP_READ: begin
          reads++;
          if (reader_gen != gen) begin
            reader_gen = gen;
            rd_cursor = (wr_count > CNT_DEPTH) ? wr_count - CNT_DEPTH : '0;
            resyncs++;
          end
          if (wr_count < rd_cursor) rd_cursor = wr_count;
          if (wr_count - rd_cursor > CNT_DEPTH) begin
            rd_cursor = wr_count - CNT_DEPTH;
            overruns++;
          end
          if (wr_count > rd_cursor) begin
            slot = slot_mem[rd_cursor[ADDR_BITS-1:0]];
            if (slot[SLOT_BITS-1:SAMPLE_BITS] == TAG_BITS'(rd_cursor + 1) &&
                slot[30:23] != 8'hFF) begin
              want.sample_out = slot[SAMPLE_BITS-1:0];
              want.sample_valid = 1'b1;
              hits++;
            end
            rd_cursor = rd_cursor + 1;
          end else begin
            zero_fills++;
            if (underruns != '1) underruns = underruns + 1;
          end
          synced = 1'b1;
        end
        default: ;
      endcase
      want.burst_end = lst;
      want.written_count = wr_count[OUT_BITS-1:0];
      want.consumed_count = synced ? rd_cursor[OUT_BITS-1:0] : '0;
      want.underrun_count = underruns;
      want.generation_out = gen;
      expected_results.push_back(want);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected %h, got %h", checked, field, want, got);
      end
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t want;
      if (expected_results.size() == 0) begin
        unexpected++;
        if (unexpected <= 10) $display("result with nothing expected: %p", got);
        return;
      end
      want = expected_results.pop_front();
      compare("sample_out", want.sample_out, got.sample_out);
      compare("sample_valid", want.sample_valid, got.sample_valid);
      compare("burst_end", want.burst_end, got.burst_end);
      compare("written_count", want.written_count, got.written_count);
      compare("consumed_count", want.consumed_count, got.consumed_count);
      compare("underrun_count", want.underrun_count, got.underrun_count);
      compare("generation_out", want.generation_out, got.generation_out);
      checked++;
    endfunction
  endclass

  logic clk;
  logic rst;
  tasr_req_if req_ch ();
  tasr_rsp_if rsp_ch ();

  ring_scoreboard sb;
  bit no_idle;
  bit long_hold_req;
  int hold_left;
  int items_sent;
  int failures;

  tagged_audio_sample_ring_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("tagged_audio_sample_ring_unit_test NOT OK");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold when the stimulus asks for it.
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result('{rsp_ch.sample_out, rsp_ch.sample_valid, rsp_ch.burst_end,
                        rsp_ch.written_count, rsp_ch.consumed_count,
                        rsp_ch.underrun_count, rsp_ch.generation_out});
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                           input logic lst);
    while (!no_idle && $urandom_range(99) < 18) begin
      req_ch.valid <= 1'b0;
      req_ch.sample_in <= $urandom;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.sample_in <= smp;
    req_ch.last_in_burst <= lst;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_accepted(op, smp, lst);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    logic sgn;
    logic [SAMPLE_BITS-1:0] r;
    sgn = 1'($urandom_range(1));
    case ($urandom_range(9))
      0, 1, 2, 3: r = {sgn, 8'($urandom_range(126)), 23'($urandom)};
      4, 5:       r = $urandom;
      6:          r = {sgn, 8'($urandom_range(254, 127)), 23'($urandom)};
      7:          r = {sgn, 8'hFF, 23'($urandom)};
      8:          r = {sgn, POS_ONE[30:0]};
      default:    r = {sgn, 31'd0};
    endcase
    return r;
  endfunction

  task automatic write_burst(input int n);
    for (int i = 0; i < n; i++) send_item(OP_WRITE, random_sample(), i == n - 1);
  endtask

  task automatic read_burst(input int n);
    for (int i = 0; i < n; i++) send_item(OP_READ, $urandom, i == n - 1);
  endtask

  initial begin
    int n;
    bit hold_done;
    bit drain_done;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.operation = OP_BEGIN;
    req_ch.sample_in = '0;
    req_ch.last_in_burst = 1'b0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    items_sent = 0;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty read, sanitizing corners, reads back, unused code, new generation.
    send_item(OP_READ, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_WRITE, 32'h0000_0000, 1'b0);
    send_item(OP_WRITE, 32'h8000_0000, 1'b0);
    send_item(OP_WRITE, POS_ONE, 1'b0);
    send_item(OP_WRITE, NEG_ONE, 1'b0);
    send_item(OP_WRITE, 32'h3F80_0001, 1'b0);
    send_item(OP_WRITE, 32'hC000_0000, 1'b0);
    send_item(OP_WRITE, 32'h7F80_0000, 1'b0);
    send_item(OP_WRITE, 32'hFF80_0000, 1'b0);
    send_item(OP_WRITE, 32'h7FC0_0000, 1'b0);
    send_item(OP_WRITE, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_WRITE, 32'h7F7F_FFFF, 1'b0);
    send_item(OP_WRITE, 32'h0000_0001, 1'b0);
    send_item(OP_WRITE, 32'h3F7F_FFFF, 1'b1);
    read_burst(5);
    send_item(OP_UNUSED, 32'hA5A5_5A5A, 1'b1);
    send_item(OP_BEGIN, 32'h5A5A_A5A5, 1'b0);
    send_item(OP_READ, 32'h0, 1'b1);
    write_burst(2);
    send_item(OP_READ, 32'h0, 1'b0);

    // Random traffic: mostly write bursts followed by read bursts.
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = (items_sent >= 450 && items_sent < 650);
      if (!hold_done && items_sent >= 300) begin
        hold_done = 1'b1;
        long_hold_req = 1'b1;
        write_burst(20);
        read_burst(20);
      end
      if (!drain_done && items_sent >= 750) begin
        drain_done = 1'b1;
        req_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(negedge clk);
      end
      n = $urandom_range(99);
      if (n < 5) begin
        send_item(OP_BEGIN, $urandom, 1'($urandom_range(1)));
      end else if (n < 8) begin
        send_item(OP_UNUSED, $urandom, 1'($urandom_range(1)));
      end else if (n < 12) begin
        send_item(2'($urandom_range(2)), random_sample(), 1'($urandom_range(1)));
      end else begin
        write_burst($urandom_range(1, 24));
        read_burst($urandom_range(1, 28));
      end
    end
    no_idle = 1'b0;

    // Short tail: a synced reader in a new generation, then a resync after a refill.
    send_item(OP_BEGIN, $urandom, 1'b0);
    send_item(OP_READ, $urandom, 1'b1);
    write_burst(6);
    read_burst(4);
    send_item(OP_BEGIN, $urandom, 1'b0);
    write_burst(3);
    read_burst(5);

    req_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    failures = sb.mismatches + sb.unexpected + sb.expected_results.size();
    $display("%0d transactions, %0d results checked; %0d generations started",
             items_sent, sb.checked, sb.begins);
    $display("%0d reads: %0d samples, %0d empty, %0d overrun skips, %0d resyncs, %0d sanitized",
             sb.reads, sb.hits, sb.zero_fills, sb.overruns, sb.resyncs, sb.sanitized);
    if (failures == 0) begin
      $display("tagged_audio_sample_ring_unit_test OK");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing results",
               sb.mismatches, sb.unexpected, sb.expected_results.size());
      $display("tagged_audio_sample_ring_unit_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tasr_pkg.sv
rtl/tasr_req_if.sv
rtl/tasr_rsp_if.sv
rtl/tasr_out_stage.sv
rtl/tagged_audio_sample_ring_unit.sv
sim/tagged_audio_sample_ring_unit_test.sv
